### design/utf8_to_ascii_transliterator_defines.svh
// Assertion macros used by the UTF-8 to ASCII transliterator RTL
`ifndef UTF8_TO_ASCII_TRANSLITERATOR_DEFINES_SVH
`define UTF8_TO_ASCII_TRANSLITERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define UTA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define UTA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/uta_pkg.sv
// Types, constants and the accented-letter table of the UTF-8 to ASCII transliterator
package uta_pkg;

	localparam logic [6:0] CHAR_SPACE    = 7'd32;
	localparam logic [6:0] CHAR_TILDE    = 7'd126;
	localparam logic [6:0] CHAR_QUESTION = 7'd63;
	localparam logic [7:0] LIMIT_RESET   = 8'd255;
	localparam logic [7:0] COUNT_MAX     = 8'd255;
	localparam logic [1:0] SKIP_THREE_BYTE = 2'd2;
	localparam logic [1:0] SKIP_FOUR_BYTE  = 2'd3;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_beat_t;

	typedef struct packed {
		logic [6:0] ascii_char;
		logic       has_char;
		logic       text_done;
	} out_beat_t;

	// Map an 11-bit codepoint to its base letter, '?' when not in the table
	function automatic logic [6:0] translit(input logic [10:0] cp);
		logic [6:0] ch;
		case (cp)
			11'h104, 11'h0C4, 11'h0C0, 11'h0C1, 11'h0C2, 11'h0C3, 11'h0C5: ch = 7'h41;
			11'h105, 11'h0E4, 11'h0E0, 11'h0E1, 11'h0E2, 11'h0E3, 11'h0E5: ch = 7'h61;
			11'h106, 11'h0C7, 11'h10C: ch = 7'h43;
			11'h107, 11'h0E7, 11'h10D: ch = 7'h63;
			11'h10E: ch = 7'h44;
			11'h10F: ch = 7'h64;
			11'h118, 11'h0C9, 11'h0C8, 11'h0CA, 11'h0CB, 11'h11A: ch = 7'h45;
			11'h119, 11'h0E9, 11'h0E8, 11'h0EA, 11'h0EB, 11'h11B: ch = 7'h65;
			11'h0CD, 11'h0CC, 11'h0CE, 11'h0CF: ch = 7'h49;
			11'h0ED, 11'h0EC, 11'h0EE, 11'h0EF: ch = 7'h69;
			11'h141: ch = 7'h4C;
			11'h142: ch = 7'h6C;
			11'h143, 11'h0D1, 11'h147: ch = 7'h4E;
			11'h144, 11'h0F1, 11'h148: ch = 7'h6E;
			11'h0D3, 11'h0D6: ch = 7'h4F;
			11'h0F3, 11'h0F6: ch = 7'h6F;
			11'h158: ch = 7'h52;
			11'h159: ch = 7'h72;
			11'h15A, 11'h160: ch = 7'h53;
			11'h15B, 11'h161, 11'h0DF: ch = 7'h73;
			11'h164: ch = 7'h54;
			11'h165: ch = 7'h74;
			11'h0DC, 11'h0DA, 11'h0D9, 11'h0DB, 11'h16E: ch = 7'h55;
			11'h0FC, 11'h0FA, 11'h0F9, 11'h0FB, 11'h16F: ch = 7'h75;
			11'h0DD: ch = 7'h59;
			11'h0FD, 11'h0FF: ch = 7'h79;
			11'h179, 11'h17B, 11'h17D: ch = 7'h5A;
			11'h17A, 11'h17C, 11'h17E: ch = 7'h7A;
			default: ch = CHAR_QUESTION;
		endcase
		return ch;
	endfunction

endpackage

### design/utf8_to_ascii_transliterator.sv
// Top level of the UTF-8 to printable-ASCII transliterator
//
//  channel   | signals                      | carries
//  ----------+------------------------------+---------------------------------------
//  in        | in_valid, in_ready, in_data  | one UTF-8 byte and its end-of-text flag
//  out       | out_valid, out_ready, out_data | one ASCII character and status
//  cfg       | cfg_we, cfg_data             | out_limit, written while cfg_we is high
//
//  One byte a cycle while the result side is not stalled: a beat is held in the
//  input register, is decoded against the per-text state and is registered in
//  the result register, from which the result is offered. A stalled result
//  register holds the input register, which then holds in_ready low. Bytes that
//  give no result only update the state. Reset clears all text state and sets
//  out_limit to 255.
`include "utf8_to_ascii_transliterator_defines.svh"

module utf8_to_ascii_transliterator
	import uta_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data,
	input  logic      cfg_we,
	input  logic [7:0] cfg_data
);

	logic       valid_s1;
	in_beat_t   beat_s1;
	logic       out_valid_q;
	out_beat_t  out_q;
	logic [7:0] limit_q;

	logic [1:0] skip_q, skip_d;
	logic [4:0] lead_q, lead_d;
	logic       pend_q, pend_d;
	logic [7:0] count_q, count_d;
	logic       stop_q, stop_d;

	logic       emit;
	logic [6:0] ch;
	logic       advance;
	logic [7:0] b;
	logic       eot;

	assign b   = beat_s1.text_byte;
	assign eot = beat_s1.end_of_text;

	// a decoded beat leaves the input register when the result side has room
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_s1 <= in_data;
		end
	end

	// byte decode against the per-text state
	always_comb begin
		emit   = 1'b0;
		ch     = CHAR_SPACE;
		skip_d = skip_q;
		lead_d = lead_q;
		pend_d = pend_q;
		stop_d = stop_q;
		if (stop_q) begin
			// rest of the text is ignored
		end else if (pend_q) begin
			ch     = translit({lead_q, b[5:0]});
			emit   = 1'b1;
			pend_d = 1'b0;
			lead_d = '0;
			if (b == 8'd0) begin
				stop_d = 1'b1;
			end
		end else if (skip_q != 2'd0) begin
			skip_d = skip_q - 2'd1;
			if (b == 8'd0) begin
				stop_d = 1'b1;
				skip_d = '0;
			end
		end else if (b == 8'd0 || count_q >= limit_q) begin
			stop_d = 1'b1;
		end else if (!b[7]) begin
			ch   = (b[6:0] >= CHAR_SPACE && b[6:0] <= CHAR_TILDE) ? b[6:0] : CHAR_SPACE;
			emit = 1'b1;
		end else if (b[7:5] == 3'b110) begin
			lead_d = b[4:0];
			pend_d = 1'b1;
		end else if (b[7:4] == 4'b1110) begin
			ch     = CHAR_QUESTION;
			emit   = 1'b1;
			skip_d = SKIP_THREE_BYTE;
		end else if (b[7:3] == 5'b11110) begin
			ch     = CHAR_QUESTION;
			emit   = 1'b1;
			skip_d = SKIP_FOUR_BYTE;
		end else begin
			ch   = CHAR_SPACE;
			emit = 1'b1;
		end

		// a lead as the last byte is looked up with a zero second byte
		if (eot && pend_d && !stop_d) begin
			ch     = translit({lead_d, 6'd0});
			emit   = 1'b1;
			pend_d = 1'b0;
		end

		count_d = (emit && count_q != COUNT_MAX) ? count_q + 8'd1 : count_q;
	end

	// per-text state, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q  <= '0;
			lead_q  <= '0;
			pend_q  <= 1'b0;
			count_q <= '0;
			stop_q  <= 1'b0;
		end else if (advance) begin
			if (eot) begin
				skip_q  <= '0;
				lead_q  <= '0;
				pend_q  <= 1'b0;
				count_q <= '0;
				stop_q  <= 1'b0;
			end else begin
				skip_q  <= skip_d;
				lead_q  <= lead_d;
				pend_q  <= pend_d;
				count_q <= count_d;
				stop_q  <= stop_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit || eot;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.ascii_char <= ch;
			out_q.has_char   <= emit;
			out_q.text_done  <= eot;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks
	`UTA_ASSERT_NOW(a_pend_no_skip, pend_q, skip_q == 2'd0, "lead pending while skipping")
	`UTA_ASSERT_NOW(a_stop_no_pend, stop_q, !pend_q, "lead pending after text stop")
	`UTA_ASSERT_NOW(a_empty_is_end, out_valid_q && !out_q.has_char, out_q.text_done,
		"result without character is not end of text")
	`UTA_ASSERT_NEXT(a_end_clears, advance && eot, count_q == 8'd0 && !stop_q && !pend_q,
		"text state not cleared after end of text")

endmodule
